[hw/rtl/gsa_pkg.sv]
// Package for the grid sweep argmin block: sizes, codes and shared types.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int COORD_BITS  = 16;
    localparam int SCORE_BITS  = 32;
    localparam int SETUP_BITS  = 48;
    localparam int DCNT_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_COUNT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM0_SETUP = 3'd1;

    // Input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Result kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef coord_t [MAX_DIMS-1:0] coord_vec_t;
    typedef logic [MAX_DIMS-1:0][SETUP_BITS-1:0] setup_vec_t;

    typedef struct packed {
        logic       kind;
        score_t     score;
        coord_vec_t coord;
    } result_t;

    typedef struct packed {
        coord_vec_t          point;
        logic [MAX_DIMS-1:0] flags;
        coord_vec_t          best;
        score_t              low_score;
        logic                active;
        logic                awaiting;
    } state_t;

endpackage

[hw/rtl/gsa_step.sv]
// Next-state and result logic of the grid sweep for one input transfer.
`timescale 1ns / 1ps

module gsa_step import gsa_pkg::*; (
    input  logic [DCNT_BITS-1:0] dim_count,
    input  setup_vec_t           dim_setup,
    input  state_t               cur,
    input  logic                 op,
    input  score_t               score,
    output state_t               nxt,
    output logic                 res_valid,
    output result_t              res
);

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic coord_t sat_sum(input coord_t a, input coord_t b, input logic sub);
        logic signed [COORD_BITS:0] s;
        begin
            if (sub) begin
                s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            end else begin
                s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
            end
            if (s[COORD_BITS] != s[COORD_BITS-1]) begin
                sat_sum = s[COORD_BITS] ? C_MIN : C_MAX;
            end else begin
                sat_sum = s[COORD_BITS-1:0];
            end
        end
    endfunction

    logic [DCNT_BITS-1:0] n_eff;
    coord_vec_t           st, lo, hi, cand, adv_p, best_n, pt_out, best_out, start_out;
    logic [MAX_DIMS-1:0]  act, top, flags_in, avail, sel, below, reach, adv_f;
    logic                 any_free, first, done, upd;
    score_t               bs_n;

    always_comb begin
        if (dim_count == '0) begin
            n_eff = DCNT_BITS'(1);
        end else if (dim_count > DCNT_BITS'(MAX_DIMS)) begin
            n_eff = DCNT_BITS'(MAX_DIMS);
        end else begin
            n_eff = dim_count;
        end
    end

    assign first    = cur.awaiting;
    assign flags_in = first ? '0 : cur.flags;

    // Bounds and candidate step for every dimension
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            st[k]    = dim_setup[k][47:32];
            lo[k]    = sat_sum(dim_setup[k][47:32], dim_setup[k][31:16], 1'b1);
            hi[k]    = sat_sum(dim_setup[k][47:32], dim_setup[k][31:16], 1'b0);
            act[k]   = (k < int'(n_eff));
            top[k]   = (k == int'(n_eff) - 1);
            cand[k]  = (first || ($signed(cur.point[k]) < $signed(lo[k])))
                       ? lo[k] : sat_sum(cur.point[k], dim_setup[k][15:0], 1'b0);
            reach[k] = ($signed(cand[k]) >= $signed(hi[k]));
        end
    end

    // Lowest dimension not yet at its bound advances
    assign avail    = ~flags_in & act;
    assign sel      = avail & (~avail + MAX_DIMS'(1));
    assign any_free = |avail;
    assign below    = any_free ? (sel - MAX_DIMS'(1)) : '0;
    assign done     = !any_free || (|(sel & reach & top));

    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (sel[k]) begin
                adv_p[k] = reach[k] ? hi[k] : cand[k];
                adv_f[k] = reach[k];
            end else if (below[k]) begin
                adv_p[k] = lo[k];
                adv_f[k] = 1'b0;
            end else begin
                adv_p[k] = cur.point[k];
                adv_f[k] = flags_in[k];
            end
            // pull anything below its lower bound back up
            if (act[k] && (first || ($signed(adv_p[k]) < $signed(lo[k])))) begin
                adv_p[k] = lo[k];
            end
        end
    end

    assign upd    = first || ($signed(score) < $signed(cur.low_score));
    assign best_n = upd ? cur.point : cur.best;
    assign bs_n   = upd ? score : cur.low_score;

    // Unused dimensions report zero
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            start_out[k] = act[k] ? st[k] : '0;
            pt_out[k]    = act[k] ? adv_p[k] : '0;
            best_out[k]  = act[k] ? best_n[k] : '0;
        end
    end

    always_comb begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        if (op == OP_START) begin
            nxt.point    = start_out;
            nxt.flags    = '0;
            nxt.active   = 1'b1;
            nxt.awaiting = 1'b1;
            res_valid    = 1'b1;
            res.kind     = KIND_POINT;
            res.coord    = start_out;
        end else if (cur.active) begin
            nxt.best      = best_n;
            nxt.low_score = bs_n;
            nxt.awaiting  = 1'b0;
            nxt.point     = adv_p;
            nxt.flags     = adv_f;
            res_valid     = 1'b1;
            if (done) begin
                nxt.active = 1'b0;
                res.kind   = KIND_DONE;
                res.coord  = best_out;
                res.score  = bs_n;
            end else begin
                res.kind  = KIND_POINT;
                res.coord = pt_out;
            end
        end
    end

endmodule

[hw/rtl/gsa_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module gsa_out_buf import gsa_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
                out_data_reg  <= in_data;
            end
        end else if (in_valid) begin
            // output stalled: park the new result
            skid_data_reg  <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

[hw/rtl/grid_sweep_argmin.sv]
// Top level of the grid sweep argmin block.
`timescale 1ns / 1ps
//
// Exhaustive grid search over up to four Q12.4 dimensions with argmin tracking.
// Program dim_count and dimK_setup through the cfg_* write port while idle.
// Input transfers: s_tuser is the op (start or score), s_tdata the score.
// A start transfer returns the start point. Each score transfer scores the
// point returned last and returns the next grid point, or, once the top
// dimension reaches its upper bound, the best point and its score
// (m_tuser high). A score with no search running returns nothing.
// The result is registered onto the m_ channel. Throughput: one input
// transfer per cycle while s_tready is high; the whole step is one
// pass of logic between the search state register and the result register.
// A stalled receiver holds the output register; one more result parks in a
// skid register, and s_tready then drops until the skid drains.
// Reset (aresetn low, synchronous) clears the search state and buffers and
// sets dim_count to 1 and all setups to zero.
//
module grid_sweep_argmin import gsa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SETUP_BITS-1:0]   cfg_wdata,
    // input channel
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // [31:0] score
    input  logic                    s_tuser,   // [0] op
    // result channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [95:0]             m_tdata,   // coord0, coord1, coord2, coord3, score out
    output logic                    m_tuser    // [0] result_kind
);

    logic [DCNT_BITS-1:0] dim_count_reg;
    setup_vec_t           dim_setup_reg;
    state_t               state_reg, state_next;
    logic                 res_valid, accept;
    result_t              res, m_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= DCNT_BITS'(1);
            dim_setup_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_DIM_COUNT) begin
                dim_count_reg <= cfg_wdata[DCNT_BITS-1:0];
            end
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (cfg_index == CFG_IDX_BITS'(int'(CFG_DIM0_SETUP) + d)) begin
                    dim_setup_reg[d] <= cfg_wdata;
                end
            end
        end
    end

    assign accept = s_tvalid && s_tready;

    gsa_step u_step (
        .dim_count (dim_count_reg),
        .dim_setup (dim_setup_reg),
        .cur       (state_reg),
        .op        (s_tuser),
        .score     (s_tdata),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // Search state: advance on every accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    gsa_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (m_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {m_data.score, m_data.coord};
    assign m_tuser = m_data.kind;

endmodule
